>>> hw/rtl/iam_pkg.sv
// ---------------------------------------------------------------------------
// iam_pkg - shared types and constants for the interval availability monitor
// Word formats, opcodes, status codes and sequencer states.
// ---------------------------------------------------------------------------
package iam_pkg;

    localparam int NUM_TYPES_DEF  = 32;
    localparam int COUNT_BITS_DEF = 16;
    localparam logic [31:0] DEFAULT_INTERVAL = 32'd120000000;
    localparam logic [7:0]  VERDICT_CAP      = 8'd63;
    localparam logic [7:0]  CATCH_UP_RESET   = 8'd30;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_DONE   = 2'd1;
    localparam logic [1:0] OP_TIME   = 2'd2;
    localparam logic [1:0] OP_UNDEF  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_DOUBLE  = 2'd2;
    localparam logic [1:0] ST_NOSTAMP = 2'd3;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_MASK     = 2'd2;
    localparam logic [1:0] REG_CATCHUP  = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] now_us;
        logic [4:0]  request_type;
        logic [31:0] start_stamp;
        logic        reply_eio;
    } iam_in_t;

    typedef struct packed {
        logic        kind;
        logic        interval_available;
        logic [31:0] type_available_mask;
        logic [31:0] new_stamp;
        logic [1:0]  status;
        logic [63:0] missing_intervals;
        logic        last;
    } iam_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_DIVDONE,
        S_CHECK,
        S_ROLL,
        S_ROLLEND,
        S_MISS,
        S_APPLY,
        S_EMIT
    } iam_state_t;

    // divider control from the sequencer
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
    } iam_div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
        logic [31:0] remainder;
    } iam_div_rsp_t;

endpackage

>>> hw/rtl/iam_divider.sv
// ---------------------------------------------------------------------------
// iam_divider - radix-2 restoring divider
// 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module iam_divider
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  iam_pkg::iam_div_req_t req,
    input  logic [31:0]           divisor,
    output iam_pkg::iam_div_rsp_t rsp
);
    import iam_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[63]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[31:0];

endmodule

>>> hw/rtl/interval_availability_monitor.sv
// ---------------------------------------------------------------------------
// interval_availability_monitor - per-type availability over time intervals
// Rolls elapsed intervals per event, emits verdict words and one ack word.
// ---------------------------------------------------------------------------
// Sequence: an ignored event shows its ack word in the cycle after it is
//   taken. A first event runs one divide. Otherwise each rolled interval
//   walks the types in S_ROLL and S_ROLLEND, a realign adds two divides,
//   then the ack goes through S_APPLY and S_EMIT; output stalls add to all.
// Throughput: one event at a time; in_stall is high while busy.
// Reset: all counters and flags clear, stamps return to 1, window closed.
module interval_availability_monitor
#(
    parameter int NUM_TYPES  = iam_pkg::NUM_TYPES_DEF,
    parameter int COUNT_BITS = iam_pkg::COUNT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  iam_pkg::iam_in_t in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output iam_pkg::iam_out_t out_word,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import iam_pkg::*;

    localparam int TB = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // configuration
    logic        enable_reg;
    logic [31:0] ilen_reg;
    logic [31:0] tmask_reg;
    logic [7:0]  catch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            ilen_reg   <= DEFAULT_INTERVAL;
            tmask_reg  <= '0;
            catch_reg  <= CATCH_UP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:   enable_reg <= cfg_data[0];
                REG_INTERVAL: ilen_reg   <= cfg_data;
                REG_MASK:     tmask_reg  <= cfg_data;
                REG_CATCHUP:  catch_reg  <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    logic [31:0] period;
    assign period = (ilen_reg == '0) ? DEFAULT_INTERVAL : ilen_reg;
    logic [7:0] limit;
    assign limit = (catch_reg > VERDICT_CAP) ? VERDICT_CAP : catch_reg;

    // per-type state
    logic [COUNT_BITS-1:0] outst_reg [NUM_TYPES];
    logic [COUNT_BITS-1:0] fresh_reg [NUM_TYPES];
    logic [NUM_TYPES-1:0]  eio_reg, succ_reg;
    logic [31:0]           seq_reg   [NUM_TYPES];

    logic [63:0] wstart_reg, wstart_next;
    logic        wopen_reg, wopen_next;
    logic        skip_reg, skip_next;

    iam_state_t  state_reg, state_next;
    iam_in_t     ev_reg;
    logic [TB-1:0] tidx_reg, tidx_next;
    logic [31:0] amask_reg, amask_next;
    logic        verdict_reg, verdict_next;  // roll in progress emits a verdict
    logic [7:0]  nroll_reg, nroll_next;
    logic        realign_reg, realign_next;
    logic [63:0] miss_reg, miss_next;
    logic [63:0] aligned_reg, aligned_next;

    iam_out_t    obuf_reg, obuf_next;
    logic        ovalid_reg, ovalid_next;

    iam_div_req_t div_req;
    iam_div_rsp_t div_rsp;

    iam_divider u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .divisor (period),
        .rsp     (div_rsp)
    );

    logic [TB-1:0] ev_t;
    assign ev_t = ev_reg.request_type[TB-1:0];
    logic ev_in_range;
    assign ev_in_range = {27'd0, ev_reg.request_type} < 32'(NUM_TYPES);
    logic in_tracked;
    assign in_tracked = ({27'd0, in_word.request_type} < 32'(NUM_TYPES))
                        && tmask_reg[in_word.request_type];

    logic accept;
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || ovalid_reg;

    logic out_take;
    assign out_take = ovalid_reg && !out_stall;

    logic due;
    logic [63:0] diff;
    assign diff = ev_reg.now_us - wstart_reg;
    assign due  = (ev_reg.now_us >= wstart_reg) && (diff >= {32'd0, period});

    // boundary at or below now: now minus the remainder of now / period
    logic [63:0] aligned_w;
    assign aligned_w = ev_reg.now_us - {32'd0, div_rsp.remainder};
    logic ignored;
    assign ignored = !enable_reg || (in_word.operation == OP_UNDEF)
                     || (in_word.operation != OP_TIME && !in_tracked);

    // type walk helpers
    logic [COUNT_BITS-1:0] cur_o, cur_f;
    logic hung, failed, avail_t, cur_trk;
    assign cur_o   = outst_reg[tidx_reg];
    assign cur_f   = fresh_reg[tidx_reg];
    assign cur_trk = tmask_reg[tidx_reg];
    assign hung    = cur_o > cur_f;
    assign failed  = eio_reg[tidx_reg] || hung;
    assign avail_t = !failed || succ_reg[tidx_reg];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = ignored ? S_IDLE : (!wopen_reg ? S_DIV : S_CHECK);
            S_DIV:
                if (div_rsp.done)
                    state_next = S_DIVDONE;
            S_DIVDONE:
                state_next = realign_reg ? S_MISS : S_APPLY;
            S_CHECK:
                if (ovalid_reg)
                    state_next = S_CHECK;
                else if (skip_reg && due)
                    state_next = S_ROLL;
                else if (due && nroll_reg < limit)
                    state_next = S_ROLL;
                else if (due)
                    state_next = S_DIV;
                else
                    state_next = S_APPLY;
            S_ROLL:
                if (tidx_reg == TB'(NUM_TYPES - 1))
                    state_next = S_ROLLEND;
            S_ROLLEND:
                state_next = S_CHECK;
            S_MISS:
                if (!div_rsp.busy && !div_req.start && div_rsp.done)
                    state_next = S_APPLY;
            S_APPLY:
                if (!ovalid_reg)
                    state_next = S_EMIT;
            S_EMIT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // sequencer outputs and datapath
    logic miss_started_reg, miss_started_next;
    always_comb
    begin
        wstart_next  = wstart_reg;
        wopen_next   = wopen_reg;
        skip_next    = skip_reg;
        tidx_next    = tidx_reg;
        amask_next   = amask_reg;
        verdict_next = verdict_reg;
        nroll_next   = nroll_reg;
        realign_next = realign_reg;
        miss_next    = miss_reg;
        aligned_next = aligned_reg;
        obuf_next    = obuf_reg;
        ovalid_next  = ovalid_reg && !out_take;
        miss_started_next = miss_started_reg;
        div_req.start    = 1'b0;
        div_req.dividend = ev_reg.now_us;
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    nroll_next   = '0;
                    realign_next = 1'b0;
                    miss_next    = '0;
                    if (ignored)
                    begin
                        obuf_next   = '0;
                        obuf_next.kind      = 1'b1;
                        obuf_next.new_stamp = in_word.start_stamp;
                        obuf_next.status    = ST_IGNORED;
                        obuf_next.last      = 1'b1;
                        ovalid_next = 1'b1;
                    end
                    else if (!wopen_reg)
                        div_req.start = 1'b0;
                end
            S_DIV:
                if (!div_rsp.busy && !div_rsp.done && !miss_started_reg)
                begin
                    div_req.start = 1'b1;
                    miss_started_next = 1'b1;
                end
            S_DIVDONE:
            begin
                miss_started_next = 1'b0;
                aligned_next = aligned_w;
                if (!realign_reg)
                begin
                    wstart_next = aligned_w;
                    skip_next   = ev_reg.now_us != aligned_w;
                    wopen_next  = 1'b1;
                end
            end
            S_CHECK:
                if (!ovalid_reg)
                begin
                    tidx_next = '0;
                    amask_next = '1;
                    if (skip_reg && due)
                    begin
                        skip_next    = 1'b0;
                        verdict_next = 1'b0;
                    end
                    else if (due && nroll_reg < limit)
                        verdict_next = 1'b1;
                    else if (due)
                        realign_next = 1'b1;
                end
            S_ROLL:
            begin
                if (cur_trk && !avail_t)
                    amask_next[tidx_reg] = 1'b0;
                tidx_next = tidx_reg + TB'(1);
            end
            S_ROLLEND:
            begin
                wstart_next = wstart_reg + {32'd0, period};
                if (verdict_reg)
                begin
                    nroll_next = nroll_reg + 8'd1;
                    obuf_next  = '0;
                    obuf_next.interval_available  = &amask_reg;
                    obuf_next.type_available_mask = amask_reg;
                    ovalid_next = 1'b1;
                end
            end
            S_MISS:
                // second divide: (aligned - window_start) / period
                if (!miss_started_reg && !div_rsp.busy)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = aligned_reg - wstart_reg;
                    miss_started_next = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    miss_next   = div_rsp.quotient;
                    wstart_next = aligned_reg;
                    miss_started_next = 1'b0;
                end
            S_APPLY:
                if (!ovalid_reg)
                begin
                    obuf_next = '0;
                    obuf_next.kind = 1'b1;
                    obuf_next.last = 1'b1;
                    obuf_next.missing_intervals = miss_reg;
                    obuf_next.new_stamp = ev_reg.start_stamp;
                    obuf_next.status    = ST_OK;
                    if (ev_reg.operation == OP_START)
                    begin
                        if (ev_reg.start_stamp != '0)
                            obuf_next.status = ST_DOUBLE;
                        else
                            obuf_next.new_stamp = seq_reg[ev_t];
                    end
                    else if (ev_reg.operation == OP_DONE)
                    begin
                        obuf_next.new_stamp = '0;
                        if (ev_reg.start_stamp == '0)
                            obuf_next.status = ST_NOSTAMP;
                    end
                end
            S_EMIT:
                ovalid_next = 1'b1;
            default: ;
        endcase
    end

    // per-type state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                outst_reg[i] <= '0;
                fresh_reg[i] <= '0;
                seq_reg[i]   <= 32'd1;
            end
            eio_reg  <= '0;
            succ_reg <= '0;
        end
        else if (state_reg == S_ROLL && cur_trk)
        begin
            eio_reg[tidx_reg]   <= 1'b0;
            succ_reg[tidx_reg]  <= 1'b0;
            fresh_reg[tidx_reg] <= '0;
            seq_reg[tidx_reg]   <= (seq_reg[tidx_reg] == '1) ? 32'd1
                                   : seq_reg[tidx_reg] + 32'd1;
        end
        else if (state_reg == S_APPLY && !ovalid_reg && ev_in_range)
        begin
            if (ev_reg.operation == OP_START && ev_reg.start_stamp == '0)
            begin
                if (outst_reg[ev_t] != CMAX)
                    outst_reg[ev_t] <= outst_reg[ev_t] + COUNT_BITS'(1);
                if (fresh_reg[ev_t] != CMAX)
                    fresh_reg[ev_t] <= fresh_reg[ev_t] + COUNT_BITS'(1);
            end
            else if (ev_reg.operation == OP_DONE && ev_reg.start_stamp != '0)
            begin
                if (outst_reg[ev_t] != '0)
                    outst_reg[ev_t] <= outst_reg[ev_t] - COUNT_BITS'(1);
                if (ev_reg.start_stamp == seq_reg[ev_t] && fresh_reg[ev_t] != '0)
                    fresh_reg[ev_t] <= fresh_reg[ev_t] - COUNT_BITS'(1);
                if (ev_reg.reply_eio)
                    eio_reg[ev_t] <= 1'b1;
                else
                    succ_reg[ev_t] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wstart_reg  <= '0;
            wopen_reg   <= 1'b0;
            skip_reg    <= 1'b0;
            tidx_reg    <= '0;
            verdict_reg <= 1'b0;
            nroll_reg   <= '0;
            realign_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
            miss_started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wstart_reg  <= wstart_next;
            wopen_reg   <= wopen_next;
            skip_reg    <= skip_next;
            tidx_reg    <= tidx_next;
            verdict_reg <= verdict_next;
            nroll_reg   <= nroll_next;
            realign_reg <= realign_next;
            // ack word is loaded in APPLY, shown after EMIT
            ovalid_reg  <= (state_reg == S_APPLY) ? ovalid_reg && !out_take
                                                  : ovalid_next;
            miss_started_reg <= miss_started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ev_reg <= in_word;
        amask_reg   <= amask_next;
        miss_reg    <= miss_next;
        aligned_reg <= aligned_next;
        obuf_reg    <= obuf_next;
    end

    assign out_valid = ovalid_reg;
    assign out_word  = obuf_reg;

endmodule

>>> hw/rtl/iam_checker.sv
// ---------------------------------------------------------------------------
// iam_checker - port-level checks for the availability monitor
// Watches handshakes and word formats on the top-level ports.
// ---------------------------------------------------------------------------
module iam_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input iam_pkg::iam_out_t out_word
);
    import iam_pkg::*;

    // a verdict word never carries ack fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.kind |-> !out_word.last && out_word.status == ST_OK)
        else $error("verdict word with ack fields");

    // ack words are always marked last
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.kind |-> out_word.last)
        else $error("ack word not last");

    // no new event taken while a word waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open with pending output");

    // one event at a time: input closes right after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after accept");

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled output changed");

endmodule

bind interval_availability_monitor iam_checker u_iam_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

>>> tb/tb_interval_availability_monitor.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_interval_availability_monitor - testbench for the availability monitor
// Drives start/completion/time events, predicts verdict and ack words with a
// behavioral model of the interval roll, and checks every output word.
// ---------------------------------------------------------------------------
module tb_interval_availability_monitor;

    import iam_pkg::*;

    localparam int NT       = 32;
    localparam int CMAX     = 16'hFFFF;
    localparam int WATCHDOG = 20000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    iam_in_t  in_word;
    logic     out_valid;
    logic     out_stall;
    iam_out_t out_word;
    logic     cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    interval_availability_monitor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model configuration and state
    bit          m_enable;
    bit [31:0]   m_len_reg;
    bit [31:0]   m_tracked;
    bit [7:0]    m_catch;
    bit [15:0]   m_outst [NT];
    bit [15:0]   m_fresh [NT];
    bit          m_eio [NT];
    bit          m_ok [NT];
    bit [31:0]   m_seq [NT];
    bit [63:0]   m_wstart;
    bit          m_open;
    bit          m_partial;

    iam_out_t    expected_words[$];
    bit [31:0]   live_stamps[NT][$];
    bit [63:0]   now_clock;
    int          errors;
    int          idle_cycles;
    bit          no_idle;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit [63:0] period_us();
        return (m_len_reg == 0) ? 64'(DEFAULT_INTERVAL) : 64'(m_len_reg);
    endfunction

    function automatic bit window_due(bit [63:0] now);
        return now >= m_wstart && (now - m_wstart) >= period_us();
    endfunction

    function automatic bit [31:0] roll_interval();
        bit [31:0] avail_mask;
        bit [15:0] hung;
        bit        failed;
        avail_mask = '1;
        for (int t = 0; t < NT; t++)
        begin
            if (!m_tracked[t])
                continue;
            hung = (m_outst[t] >= m_fresh[t]) ? m_outst[t] - m_fresh[t] : '0;
            failed = m_eio[t] || hung != 0;
            if (failed && !m_ok[t])
                avail_mask[t] = 1'b0;
            m_eio[t] = 0;
            m_ok[t] = 0;
            m_fresh[t] = 0;
            m_seq[t] = m_seq[t] + 1;
            if (m_seq[t] == 0)
                m_seq[t] = 1;
        end
        m_wstart += period_us();
        return avail_mask;
    endfunction

    function automatic void push_ack(bit [31:0] stamp, bit [1:0] st, bit [63:0] miss);
        iam_out_t w;
        w = '0;
        w.kind = 1'b1;
        w.new_stamp = stamp;
        w.status = st;
        w.missing_intervals = miss;
        w.last = 1'b1;
        expected_words.push_back(w);
    endfunction

    function automatic void predict_event(iam_in_t ev);
        bit [63:0] len;
        bit [63:0] miss;
        bit [63:0] aligned;
        bit [31:0] m;
        int        cap;
        int        n;
        int        t;
        iam_out_t  w;
        t = ev.request_type;
        miss = 0;
        if (!m_enable || ev.operation == OP_UNDEF ||
            (ev.operation != OP_TIME && !m_tracked[t]))
        begin
            push_ack(ev.start_stamp, ST_IGNORED, 0);
            return;
        end
        len = period_us();
        cap = (m_catch > VERDICT_CAP) ? VERDICT_CAP : m_catch;
        if (!m_open)
        begin
            m_wstart = ev.now_us / len * len;
            m_partial = ev.now_us != m_wstart;
            m_open = 1;
        end
        else
        begin
            if (m_partial && window_due(ev.now_us))
            begin
                m_partial = 0;
                void'(roll_interval());
            end
            n = 0;
            while (window_due(ev.now_us) && n < cap)
            begin
                m = roll_interval();
                w = '0;
                w.interval_available = (m == '1);
                w.type_available_mask = m;
                expected_words.push_back(w);
                n++;
            end
            if (window_due(ev.now_us))
            begin
                aligned = ev.now_us / len * len;
                miss = (aligned - m_wstart) / len;
                m_wstart = aligned;
            end
        end
        case (ev.operation)
            OP_TIME:
                push_ack(ev.start_stamp, ST_OK, miss);
            OP_START:
                if (ev.start_stamp != 0)
                    push_ack(ev.start_stamp, ST_DOUBLE, miss);
                else
                begin
                    if (m_outst[t] < CMAX) m_outst[t]++;
                    if (m_fresh[t] < CMAX) m_fresh[t]++;
                    push_ack(m_seq[t], ST_OK, miss);
                end
            default:
                if (ev.start_stamp == 0)
                    push_ack(0, ST_NOSTAMP, miss);
                else
                begin
                    if (m_outst[t] > 0) m_outst[t]--;
                    if (ev.start_stamp == m_seq[t] && m_fresh[t] > 0) m_fresh[t]--;
                    if (ev.reply_eio) m_eio[t] = 1; else m_ok[t] = 1;
                    push_ack(0, ST_OK, miss);
                end
        endcase
    endfunction

    task automatic send_event(iam_in_t ev);
        if (!no_idle)
            while ($urandom_range(99) < 30)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        in_word  <= ev;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_event(ev);
        in_valid <= 1'b0;
        // the block is busy after every accept, so this costs no throughput
        @(posedge clk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [31:0] val);
        // registers change only with nothing in flight
        while (expected_words.size() != 0 || in_stall)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ENABLE:   m_enable  = val[0];
            REG_INTERVAL: m_len_reg = val;
            REG_MASK:     m_tracked = val;
            default:      m_catch   = val[7:0];
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // sends one event of any kind; a completion picks a held stamp if one exists
    task automatic send_op(bit [1:0] op, int t, bit [63:0] dt, bit eio = 0);
        iam_in_t   ev;
        int        k;
        now_clock += dt;
        ev = '0;
        ev.operation = op;
        ev.now_us = now_clock;
        ev.request_type = 5'(t);
        ev.reply_eio = eio;
        if (op == OP_DONE && live_stamps[t].size() != 0)
        begin
            k = $urandom_range(live_stamps[t].size() - 1);
            ev.start_stamp = live_stamps[t][k];
            live_stamps[t].delete(k);
        end
        send_event(ev);
        if (op == OP_START && m_enable && m_tracked[t] && live_stamps[t].size() < 8)
            live_stamps[t].push_back(m_seq[t]);
    endtask

    task automatic send_raw(iam_in_t ev);
        send_event(ev);
    endtask

    task automatic test_directed();
        iam_in_t ev;
        // disabled: ignored
        ev = '0;
        ev.operation = OP_START;
        ev.start_stamp = 32'h1234;
        send_raw(ev);
        write_reg(REG_ENABLE, 1);
        write_reg(REG_MASK, 32'h8000_0001);
        write_reg(REG_INTERVAL, 1000);
        write_reg(REG_CATCHUP, 30);
        // untracked type
        ev.request_type = 5;
        ev.now_us = 500;
        send_raw(ev);
        // first event mid-interval opens a partial window
        now_clock = 500;
        send_op(OP_START, 0, 0);
        send_op(OP_START, 31, 100);
        send_op(OP_DONE, 0, 600, 1);
        send_op(OP_TIME, 0, 1000);
        // double registration, completion without stamp, undefined op
        ev = '0;
        ev.operation = OP_START;
        ev.request_type = 31;
        ev.now_us = now_clock;
        ev.start_stamp = '1;
        ev.reply_eio = 1;
        send_raw(ev);
        ev.operation = OP_DONE;
        ev.start_stamp = 0;
        send_raw(ev);
        ev.operation = OP_UNDEF;
        send_raw(ev);
        // hung request over many intervals, then catch-up overflow
        send_op(OP_TIME, 0, 5000);
        send_op(OP_TIME, 0, 100000);
        // time going backwards
        ev = '0;
        ev.operation = OP_TIME;
        ev.now_us = 10;
        send_raw(ev);
        send_op(OP_DONE, 31, 0, 0);
        send_op(OP_DONE, 0, 1000, 0);
        drain();
    endtask

    task automatic test_catch_up_extremes();
        write_reg(REG_CATCHUP, 255);
        send_op(OP_TIME, 0, 1000 * 70);
        drain();
        write_reg(REG_CATCHUP, 0);
        send_op(OP_TIME, 0, 1000 * 5);
        drain();
        write_reg(REG_CATCHUP, 1);
        send_op(OP_TIME, 0, 1000 * 3);
        drain();
    endtask

    task automatic test_random(int count, bit [31:0] len, bit [31:0] mask);
        int  t;
        int  r;
        bit [63:0] dt;
        write_reg(REG_INTERVAL, len);
        write_reg(REG_MASK, mask);
        write_reg(REG_CATCHUP, $urandom_range(1, 8));
        for (int i = 0; i < count; i++)
        begin
            no_idle = (i >= count / 3 && i < count / 2);
            t = $urandom_range(NT - 1);
            if ($urandom_range(3) != 0)
                t = t % 4;
            dt = (len == 0) ? 64'($urandom_range(30_000_000))
                            : 64'($urandom_range(len / 2 + 1));
            if ($urandom_range(30) == 0)
                dt = 64'(len) * $urandom_range(20);
            r = $urandom_range(99);
            if (r < 45)
                send_op(OP_START, t, dt);
            else if (r < 85)
                send_op(OP_DONE, t, dt, $urandom_range(1));
            else
            begin
                send_op(OP_TIME, t, dt);
            end
            if (i == count / 4)
                drain();   // sender waits for all results
        end
        no_idle = 0;
        drain();
    endtask

    task automatic test_random_fields(int count);
        iam_in_t ev;
        // top of the time range: now_us at its largest value
        ev = '0;
        ev.operation = OP_TIME;
        ev.now_us = '1;
        ev.start_stamp = 32'hFFFF_FFFF;
        send_raw(ev);
        for (int i = 0; i < count; i++)
        begin
            ev.operation    = 2'($urandom_range(3));
            ev.now_us       = {$urandom, $urandom};
            ev.request_type = 5'($urandom);
            ev.start_stamp  = ($urandom_range(1)) ? $urandom : 32'd0;
            ev.reply_eio    = $urandom_range(1);
            send_raw(ev);
        end
        drain();
    endtask

    // output side: random stall, check each word
    initial
    begin
        iam_out_t e;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected output word %h", out_word);
                    errors++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (out_word.kind !== e.kind)
                    begin
                        $error("kind exp %0d got %0d", e.kind, out_word.kind);
                        errors++;
                    end
                    if (out_word.interval_available !== e.interval_available)
                    begin
                        $error("interval_available exp %0d got %0d",
                               e.interval_available, out_word.interval_available);
                        errors++;
                    end
                    if (out_word.type_available_mask !== e.type_available_mask)
                    begin
                        $error("type_available_mask exp %h got %h",
                               e.type_available_mask, out_word.type_available_mask);
                        errors++;
                    end
                    if (out_word.new_stamp !== e.new_stamp)
                    begin
                        $error("new_stamp exp %h got %h", e.new_stamp, out_word.new_stamp);
                        errors++;
                    end
                    if (out_word.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, out_word.status);
                        errors++;
                    end
                    if (out_word.missing_intervals !== e.missing_intervals)
                    begin
                        $error("missing_intervals exp %0d got %0d",
                               e.missing_intervals, out_word.missing_intervals);
                        errors++;
                    end
                    if (out_word.last !== e.last)
                    begin
                        $error("last exp %0d got %0d", e.last, out_word.last);
                        errors++;
                    end
                end
            end
            out_stall <= !no_idle && ($urandom_range(99) < 30);
        end
    end

    // watchdog on cycles with no accepted word on either side
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        errors    = 0;
        no_idle   = 0;
        now_clock = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        m_enable  = 0;
        m_len_reg = DEFAULT_INTERVAL;
        m_tracked = 0;
        m_catch   = CATCH_UP_RESET;
        for (int t = 0; t < NT; t++)
        begin
            m_outst[t] = 0;
            m_fresh[t] = 0;
            m_eio[t]   = 0;
            m_ok[t]    = 0;
            m_seq[t]   = 1;
        end
        m_wstart  = 0;
        m_open    = 0;
        m_partial = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_catch_up_extremes();
        test_random(180, 1000, 32'h0000_000F);
        test_random(120, 0, 32'hFFFF_FFFF);
        test_random(60, 32'hFFFF_FFFF, 32'h8000_0003);
        test_random_fields(40);
        write_reg(REG_ENABLE, 0);
        test_random_fields(10);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/iam_pkg.sv
hw/rtl/iam_divider.sv
hw/rtl/interval_availability_monitor.sv
hw/rtl/iam_checker.sv
tb/tb_interval_availability_monitor.sv
